// ===== hdl/ftws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_pkg
// Shared constants and the command and status bundles that pass between the
// frame time statistics controller and its datapath.
// ----------------------------------------------------------------------------
package ftws_pkg;

  localparam int DEF_WINDOW    = 64;
  localparam int DEF_TIME_BITS = 32;

  localparam int IN_W  = 32;
  localparam int OUT_W = 32;
  localparam int CFG_W = 32;

  localparam logic [CFG_W-1:0] TPS_RESET = 32'd1000000;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;        // take the input transfer and write the new delta
    logic div_start;     // load operands into the divider and start it
    logic div_rate;      // divider operands: 0 = sum / fill, 1 = tps / mean
    logic mean_capture;  // latch the mean from the divider
    logic rate_capture;  // latch the rounded rate from the divider
    logic out_load;      // move the finished result into the output register
  } ftws_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;     // every filled entry has been accumulated
    logic div_busy;      // divider is iterating
    logic div_done;      // divider finished last cycle, quotient is final
    logic mean_zero;     // latched mean is zero
    logic out_free;      // output register can take a result this cycle
  } ftws_sts_t;

endpackage

// ===== hdl/ftws_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftws_div #(
  parameter int DVD_W = 39,
  parameter int DSR_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DSR_W-1:0] remainder
);

  localparam int CW = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while iterating");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding iteration");

endmodule

// ===== hdl/ftws_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_dp
// Datapath: delta ring memory, window scan with sum and maximum, shared
// divider, rate rounding, configuration register and output register.
// ----------------------------------------------------------------------------
module ftws_dp
  import ftws_pkg::*;
#(
  parameter int WINDOW    = DEF_WINDOW,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ftws_cmd_t        cmd,
  output ftws_sts_t        sts,
  input  logic [IN_W-1:0]  in_now_time,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_ticks_per_second,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_avg_time,
  output logic [OUT_W-1:0] out_worst_time,
  output logic [OUT_W-1:0] out_rate_per_second,
  output logic             out_valid_res
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SW    = TIME_BITS + CNT_W;
  localparam int DVD_W = (SW > CFG_W) ? SW : CFG_W;
  localparam int DSR_W = (TIME_BITS > CNT_W) ? TIME_BITS : CNT_W;

  typedef logic [TIME_BITS-1:0] time_t;

  // Ring of frame deltas.
  time_t ring_mem [WINDOW];

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]    wi_r, wi_nxt;
  time_t            last_time_r;
  time_t            delta;
  logic [CFG_W-1:0] tps_r;

  logic             issue_r;
  logic             rd_vld_r;
  logic [AW-1:0]    addr_r;
  time_t            rd_data_r;
  logic [SW-1:0]    sum_r;
  time_t            worst_r;

  time_t            mean_r;
  logic [OUT_W-1:0] rate_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] avg_out_r, worst_out_r, rate_out_r;
  logic             valid_res_r;

  logic             div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DSR_W-1:0] div_dsr, div_rem;
  logic             round_up;

  // Fill count saturates at the window size; the first slot written after
  // reset is slot zero, after which the index walks round the ring.
  always_comb begin
    fill_nxt = (fill_r == CNT_W'(WINDOW)) ? fill_r : fill_r + 1'b1;
    if (fill_r == '0 || wi_r == AW'(WINDOW - 1)) begin
      wi_nxt = '0;
    end else begin
      wi_nxt = wi_r + 1'b1;
    end
    delta = time_t'(in_now_time) - last_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      wi_r        <= '0;
      last_time_r <= '0;
      tps_r       <= TPS_RESET;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tps_r <= cfg_ticks_per_second;
      end
      if (cmd.accept) begin
        fill_r      <= fill_nxt;
        wi_r        <= wi_nxt;
        last_time_r <= time_t'(in_now_time);
        issue_r     <= 1'b1;
      end else if (issue_r && ({{(CNT_W > AW ? CNT_W - AW : 0){1'b0}}, addr_r}
                               == CNT_W'(fill_r - 1'b1))) begin
        issue_r <= 1'b0;
      end
      rd_vld_r <= issue_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[wi_nxt] <= delta;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_r) begin
      rd_data_r <= ring_mem[addr_r];
    end
  end

  // Scan address and accumulators.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r  <= '0;
      sum_r   <= '0;
      worst_r <= '0;
    end else begin
      if (issue_r) begin
        addr_r <= addr_r + 1'b1;
      end
      if (rd_vld_r) begin
        sum_r <= sum_r + SW'(rd_data_r);
        if (rd_data_r > worst_r) begin
          worst_r <= rd_data_r;
        end
      end
    end
  end

  always_comb begin
    if (cmd.div_rate) begin
      div_dvd = DVD_W'(tps_r);
      div_dsr = DSR_W'(mean_r);
    end else begin
      div_dvd = DVD_W'(sum_r);
      div_dsr = DSR_W'(fill_r);
    end
    round_up = ({div_rem, 1'b0} >= {1'b0, DSR_W'(mean_r)});
  end

  ftws_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_capture) begin
      mean_r <= div_quo[TIME_BITS-1:0];
    end
    if (cmd.rate_capture) begin
      rate_r <= OUT_W'(div_quo) + OUT_W'(round_up);
    end
    if (cmd.out_load) begin
      avg_out_r   <= OUT_W'(mean_r);
      worst_out_r <= OUT_W'(worst_r);
      rate_out_r  <= (mean_r == '0) ? '0 : rate_r;
      valid_res_r <= (mean_r != '0);
    end
  end

  always_comb begin
    sts.scan_done = !issue_r && !rd_vld_r;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.mean_zero = (mean_r == '0);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid           = out_valid_r;
  assign out_avg_time        = avg_out_r;
  assign out_worst_time      = worst_out_r;
  assign out_rate_per_second = rate_out_r;
  assign out_valid_res       = valid_res_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |-> ({{(CNT_W > AW ? CNT_W - AW : 0){1'b0}}, addr_r} < fill_r))
    else $error("scan read outside the filled entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

endmodule

// ===== hdl/ftws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_ctrl
// Sequencer: accept, scan, mean division, rate division, result hand-off.
// ----------------------------------------------------------------------------
module ftws_ctrl
  import ftws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output ftws_cmd_t cmd,
  input  ftws_sts_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_MEAN_DIV = 6'b000100,
    ST_RATE_SEL = 6'b001000,
    ST_RATE_DIV = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_MEAN_DIV;
        end
      end
      ST_MEAN_DIV: begin
        if (sts.div_done) begin
          cmd.mean_capture = 1'b1;
          state_nxt        = ST_RATE_SEL;
        end
      end
      ST_RATE_SEL: begin
        if (sts.mean_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_rate  = 1'b1;
          state_nxt     = ST_RATE_DIV;
        end
      end
      ST_RATE_DIV: begin
        cmd.div_rate = 1'b1;
        if (sts.div_done) begin
          cmd.rate_capture = 1'b1;
          state_nxt        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divide started while divider busy");

endmodule

// ===== hdl/frame_time_window_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_window_stats
// Sliding-window mean, maximum and event rate of frame-to-frame times.
// ----------------------------------------------------------------------------
// Each input transfer is one frame tick carrying the free-running timestamp
// in_now_time. The block stores the difference from the previous timestamp
// (modulo 2^TIME_BITS; the first difference after reset is the timestamp
// itself) in a ring of WINDOW entries, then returns one result transfer: the
// integer mean and the maximum of the entries filled so far, and the rate
// ticks_per_second / mean rounded to nearest with halves rounded up.
// out_valid_res is low, and the rate zero, when the mean is zero. One item
// is worked at a time. The scan reads the filled entries (at most WINDOW)
// of the ring memory one entry a cycle, and the mean and the rate each pass
// through the same bit-serial divider, one quotient bit a cycle, for a
// dividend of max(TIME_BITS + clog2(WINDOW+1), 32) bits. A finished
// result waits in the output register while the next item is accepted and
// worked. ticks_per_second is written through the cfg port, which is always
// ready and must be written only while idle. The ring needs no clearing
// pass after reset, because only entries already written are ever read.
// ----------------------------------------------------------------------------
module frame_time_window_stats
  import ftws_pkg::*;
#(
  parameter int WINDOW    = DEF_WINDOW,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel: one frame tick per transfer.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  in_now_time,
  // Result channel: one result per input transfer.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_avg_time,
  output logic [OUT_W-1:0] out_worst_time,
  output logic [OUT_W-1:0] out_rate_per_second,
  output logic             out_valid_res,
  // Configuration write channel for ticks_per_second.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_ticks_per_second
);

  ftws_cmd_t cmd;
  ftws_sts_t sts;

  // Configuration writes must be made only while idle; the block does not
  // enforce this, and a write transfer is always taken at once.
  assign cfg_ready = 1'b1;

  // The controller steps through accept, scan, the two divisions and the
  // hand-off to the output register.
  ftws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the ring, accumulators, divider and result registers.
  ftws_dp #(
    .WINDOW    (WINDOW),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_now_time          (in_now_time),
    .cfg_valid            (cfg_valid),
    .cfg_ticks_per_second (cfg_ticks_per_second),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_avg_time         (out_avg_time),
    .out_worst_time       (out_worst_time),
    .out_rate_per_second  (out_rate_per_second),
    .out_valid_res        (out_valid_res)
  );

endmodule

// ===== verif/frame_time_window_stats_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_window_stats_tb
// Self-checking testbench for the sliding-window frame time statistics block.
// Frame ticks are sent with random gaps and results are taken with random
// stalls. A behavioural model of the delta ring works out the mean, maximum
// and rate for every accepted tick. Each result transfer is then checked
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module frame_time_window_stats_tb;
  import ftws_pkg::*;

  localparam int WINDOW          = DEF_WINDOW;
  localparam int IDLE_LIMIT      = 4000;  // cycles without any transfer
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES    = 200;   // quiet time after the last result
  localparam int RANDOM_FRAMES   = 250;   // per ticks_per_second setting

  // One expected result transfer.
  typedef struct {
    logic [OUT_W-1:0] avg_time;
    logic [OUT_W-1:0] worst_time;
    logic [OUT_W-1:0] rate_per_second;
    logic             valid_res;
  } frame_stats_t;

  // Clock, reset and every input of the block start at known values.
  logic             clk                  = 1'b0;
  logic             rst_n                = 1'b0;
  logic             in_valid             = 1'b0;
  logic [IN_W-1:0]  in_now_time          = '0;
  logic             cfg_valid            = 1'b0;
  logic [CFG_W-1:0] cfg_ticks_per_second = '0;
  logic             rx_stall             = 1'b0;
  int               hold_left            = 0;

  logic             in_stall;
  logic             out_valid;
  logic             out_stall;
  logic [OUT_W-1:0] out_avg_time;
  logic [OUT_W-1:0] out_worst_time;
  logic [OUT_W-1:0] out_rate_per_second;
  logic             out_valid_res;
  logic             cfg_ready;

  // The result side stalls either for its per-transfer wait or while a long
  // hold-off is counting down.
  assign out_stall = rx_stall | (hold_left != 0);

  always #4 clk = ~clk;

  frame_time_window_stats dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_time          (in_now_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_avg_time         (out_avg_time),
    .out_worst_time       (out_worst_time),
    .out_rate_per_second  (out_rate_per_second),
    .out_valid_res        (out_valid_res),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the block's state. The ring holds frame deltas; the slot
  // pointer advances modulo the fill count, so the first delta after reset
  // lands in slot 0 and the ring fills upwards before wrapping.
  // --------------------------------------------------------------------------
  logic [IN_W-1:0]  delta_hist [WINDOW];
  int unsigned      hist_fill   = 0;
  int unsigned      hist_slot   = 0;
  logic [IN_W-1:0]  prev_stamp  = '0;
  logic [CFG_W-1:0] tps_shadow  = TPS_RESET;

  frame_stats_t     pending_stats [$];   // predictions awaiting their result
  int               mismatch_count = 0;
  logic [IN_W-1:0]  frame_stamp    = '0; // timestamp of the latest frame sent

  // Idle behaviour of each side, switched between phases of the test.
  bit               tx_gaps_on   = 1'b1;
  bit               rx_stalls_on = 1'b1;

  // Stores the new delta and returns the window statistics the block should
  // report for this tick.
  function automatic frame_stats_t predict_window_stats(input logic [IN_W-1:0] now);
    frame_stats_t     res;
    logic [63:0]      total;
    logic [63:0]      mean;
    logic [63:0]      quo;
    logic [63:0]      rem;
    logic [IN_W-1:0]  worst;
    if (hist_fill < WINDOW) hist_fill++;
    hist_slot = (hist_slot + 1) % hist_fill;
    // The subtraction wraps at 32 bits, so a timestamp that went backwards
    // gives a large delta. The first delta after reset is the stamp itself.
    delta_hist[hist_slot] = now - prev_stamp;
    prev_stamp = now;
    total = '0;
    worst = '0;
    for (int i = 0; i < hist_fill; i++) begin
      total += {32'd0, delta_hist[i]};
      if (delta_hist[i] > worst) worst = delta_hist[i];
    end
    mean = total / hist_fill;
    quo  = '0;
    // A zero mean gives no rate at all. Otherwise round to nearest, with an
    // exact half rounding up.
    if (mean != 0) begin
      quo = {32'd0, tps_shadow} / mean;
      rem = {32'd0, tps_shadow} % mean;
      if (rem != 0 && rem >= mean - rem) quo++;
    end
    res.avg_time        = mean[OUT_W-1:0];
    res.worst_time      = worst;
    res.rate_per_second = quo[OUT_W-1:0];
    res.valid_res       = (mean != 0);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Sends one frame tick. Must be called at a rising edge. Valid is left high
  // after the transfer, so that a following tick with no gap keeps it high
  // without it being lowered and raised in the same time step.
  // --------------------------------------------------------------------------
  task automatic send_frame(input logic [IN_W-1:0] now);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_now_time <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    // The transfer happened at this edge: predict its result.
    frame_stamp = now;
    pending_stats.push_back(predict_window_stats(now));
  endtask

  // Lowers valid and waits until every predicted result has been taken. As
  // every tick gives exactly one result, the block is idle after this.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes ticks_per_second while the block is idle.
  task automatic write_tps(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid            <= 1'b1;
    cfg_ticks_per_second <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    tps_shadow  = value;
  endtask

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // The first ticks run with the reset value of ticks_per_second. A zero
  // first timestamp gives a zero mean. The window {0, 4, 2} then has a mean
  // of 2, so odd rates land exactly on a half and must round up.
  task automatic test_reset_and_rounding();
    send_frame(32'd0);
    send_frame(32'd4);
    write_tps(32'd7);
    send_frame(32'd6);
    write_tps(32'd1);
    send_frame(32'd8);
    // A zero ticks_per_second gives a zero rate while the mean stays valid.
    write_tps(32'd0);
    send_frame(32'd10);
  endtask

  // Largest register value, a repeated stamp, timestamps that wrap backwards
  // and alternating bit patterns.
  task automatic test_timestamp_extremes();
    write_tps(32'hFFFF_FFFF);
    send_frame(32'd10);
    send_frame(32'd9);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h0000_0000);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h8000_0000);
    send_frame(32'h7FFF_FFFF);
    send_frame(32'h5555_5555);
    send_frame(32'hAAAA_AAAA);
    write_tps(TPS_RESET);
    send_frame(32'hAAAA_AAAB);
  endtask

  // Enough identical stamps to fill the whole window with zero deltas, so
  // the mean drops to zero again with the ring full, then one real delta.
  task automatic test_zero_mean_full_window();
    logic [IN_W-1:0] stamp;
    stamp = $urandom;
    repeat (WINDOW + 1) send_frame(stamp);
    send_frame(stamp + $urandom_range(1, 5000));
  endtask

  // The receiver holds off for a long stretch while the sender keeps on
  // offering ticks with no gaps: the output register fills, the next tick
  // is worked, and then the input channel has to stall.
  task automatic test_output_hold_off();
    drain_results();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_left   <= HOLD_OFF_CYCLES;
    repeat (30) send_frame(frame_stamp + $urandom_range(100, 5000));
    drain_results();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Random runs of frames. Most runs are steady frame streams with jitter
  // around a base delta of small, medium or full-range size; the rest are
  // repeated stamps, random stamps, backward steps and near-maximum deltas.
  task automatic run_random_frames(input int count);
    int              sent;
    int              run_len;
    int              kind;
    int              mag;
    logic [IN_W-1:0] step_base;
    sent = 0;
    while (sent < count) begin
      run_len      = $urandom_range(1, 24);
      kind         = $urandom_range(0, 9);
      mag          = $urandom_range(0, 2);
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      case (mag)
        0:       step_base = $urandom_range(0, 40);
        1:       step_base = $urandom_range(1000, 200000);
        default: step_base = $urandom;
      endcase
      for (int i = 0; i < run_len && sent < count; i++) begin
        case (kind)
          6:       send_frame(frame_stamp);
          7:       send_frame($urandom);
          8:       send_frame(frame_stamp - $urandom_range(1, 1000));
          9:       send_frame(frame_stamp + 32'hFFFF_FFFF - $urandom_range(0, 3));
          default: send_frame(frame_stamp + step_base + $urandom_range(0, step_base >> 3));
        endcase
        sent++;
      end
    end
  endtask

  // Several register settings, the extremes among them, each followed by a
  // block of random frames.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] tps_settings [5];
    tps_settings[0] = TPS_RESET;
    tps_settings[1] = 32'd1;
    tps_settings[2] = 32'hFFFF_FFFF;
    tps_settings[3] = $urandom_range(1, 1000);
    tps_settings[4] = $urandom;
    foreach (tps_settings[k]) begin
      write_tps(tps_settings[k]);
      run_random_frames(RANDOM_FRAMES);
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Long hold-off counter, driven only from here once it has been loaded.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // --------------------------------------------------------------------------
  // Result side: waits a random number of cycles before each result, then
  // takes the transfer and checks it against the oldest prediction.
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    frame_stats_t want;
    int           wait_cycles;
    wait (rst_n === 1'b1);
    forever begin
      wait_cycles = rx_stalls_on ? $urandom_range(0, 16) : 0;
      if (wait_cycles != 0) begin
        rx_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      if (pending_stats.size() == 0) begin
        report_mismatch("result transfer with no frame tick outstanding");
      end else begin
        want = pending_stats.pop_front();
        if (out_avg_time !== want.avg_time)
          report_mismatch($sformatf("avg_time %0d, expected %0d",
                                    out_avg_time, want.avg_time));
        if (out_worst_time !== want.worst_time)
          report_mismatch($sformatf("worst_time %0d, expected %0d",
                                    out_worst_time, want.worst_time));
        if (out_rate_per_second !== want.rate_per_second)
          report_mismatch($sformatf("rate_per_second %0d, expected %0d",
                                    out_rate_per_second, want.rate_per_second));
        if (out_valid_res !== want.valid_res)
          report_mismatch($sformatf("valid_res %b, expected %b",
                                    out_valid_res, want.valid_res));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long run of cycles with no transfer on any channel means the
  // block has hung. The limit covers the slowest item, the longest gaps on
  // both sides and the long hold-off several times over.
  // --------------------------------------------------------------------------
  wire any_transfer = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                      (cfg_valid && cfg_ready);

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (any_transfer === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("frame_time_window_stats test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_rounding();
    test_timestamp_extremes();
    test_zero_mean_full_window();
    test_output_hold_off();
    test_random_traffic();

    // Let the last results arrive, then watch for any stray transfer.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_stats.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_stats.size()));

    if (mismatch_count == 0) begin
      $display("frame_time_window_stats test passed");
    end else begin
      $display("frame_time_window_stats test failed");
    end
    $finish;
  end

endmodule
